// ----- design/assert_macros.svh -----
// Assertion helpers used by the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- design/tbs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_pkg
// Types, constants and arithmetic helpers of the texture bilinear sampler.
// ----------------------------------------------------------------------------
package tbs_pkg;

	localparam int TEXEL_WORDS     = 4096;
	localparam int ADDR_W          = $clog2(TEXEL_WORDS);
	localparam int MAX_LOG2_EXTENT = 6;
	localparam int IDX_W           = MAX_LOG2_EXTENT;
	localparam int LG_W            = 3;
	localparam int S_TDATA_W       = 112;
	localparam int CFG_ADDR_W      = 4;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NONFINITE = 2'd1;
	localparam logic [1:0] ST_OVERFLOW  = 2'd2;

	localparam logic [1:0] FR_NONE  = 2'd0;
	localparam logic [1:0] FR_BELOW = 2'd1;
	localparam logic [1:0] FR_HALF  = 2'd2;
	localparam logic [1:0] FR_ABOVE = 2'd3;

	localparam logic [1:0] REG_LOG2_WIDTH  = 2'd0;
	localparam logic [1:0] REG_LOG2_HEIGHT = 2'd1;
	localparam logic [1:0] REG_FILTER_MODE = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_READ,
		S_LERP_X,
		S_LERP_Y,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [LG_W-1:0] log2_width;
		logic [LG_W-1:0] log2_height;
		logic            filter_mode;
	} cfg_t;

	typedef struct packed {
		logic       wr_en;
		logic       capture;
		logic       decode;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       lerp_x;
		logic       lerp_y;
		logic       load_out;
	} cmd_t;

	typedef struct packed {
		logic bilinear;
		logic out_free;
	} sts_t;

	typedef struct packed {
		logic [1:0]       st;
		logic [IDX_W-1:0] lo;
		logic [IDX_W-1:0] hi;
		logic [7:0]       w;
	} axis_t;

	function automatic logic [LG_W-1:0] sat_lg(input logic [LG_W-1:0] lg);
		return (lg > LG_W'(MAX_LOG2_EXTENT)) ? LG_W'(MAX_LOG2_EXTENT) : lg;
	endfunction

	// binary32 coordinate times extent, floored; when bilinear, times 256, rounded to nearest even, minus 128
	function automatic axis_t axis_decode(input logic [31:0] bits, input logic [LG_W-1:0] lg,
			input logic bil);
		axis_t            r;
		logic [7:0]       e;
		logic [23:0]      m;
		logic [3:0]       k;
		logic signed [10:0] s;
		logic [55:0]      sh;
		logic [15:0]      ip;
		logic [15:0]      mag;
		logic [15:0]      c;
		logic [7:0]       ci;
		logic [1:0]       frac;
		logic             ovf;
		logic             neg;
		logic [IDX_W-1:0] msk;
		e    = bits[30:23];
		neg  = bits[31];
		m    = (e == 8'd0) ? {1'b0, bits[22:0]} : {1'b1, bits[22:0]};
		k    = bil ? (4'(lg) + 4'd8) : 4'(lg);
		s    = $signed({3'b000, (e == 8'd0) ? 8'd1 : e}) - 11'sd150
			+ $signed({7'b0000000, k});
		ip   = '0;
		frac = FR_NONE;
		ovf  = 1'b0;
		sh   = '0;
		msk  = ~({IDX_W{1'b1}} << lg);
		if (m == 24'd0) begin
		end else if (!s[10]) begin
			if (s >= 11'sd40)
				ovf = bil || !(neg && s == 11'sd40 && bits[22:0] == 23'd0);
			else if (s < 11'sd16)
				ip = 16'(40'(m) << s[3:0]);
		end else if (s < -11'sd31) begin
			frac = FR_BELOW;
		end else begin
			sh = {m, 32'd0} >> 5'(-s);
			ip = sh[47:32];
			if (sh[31:0] == 32'd0)
				frac = FR_NONE;
			else if (sh[31:0] == 32'h8000_0000)
				frac = FR_HALF;
			else if (!sh[31])
				frac = FR_BELOW;
			else
				frac = FR_ABOVE;
		end
		if (bil) begin
			mag = ip + 16'((frac == FR_ABOVE || (frac == FR_HALF && ip[0])) ? 1 : 0);
			c   = (neg ? (16'd0 - mag) : mag) - 16'd128;
		end else begin
			mag = ip + 16'((neg && frac != FR_NONE) ? 1 : 0);
			c   = neg ? (16'd0 - mag) : mag;
		end
		ci   = bil ? c[15:8] : c[7:0];
		r.w  = c[7:0];
		r.lo = ci[IDX_W-1:0] & msk;
		r.hi = (ci[IDX_W-1:0] + IDX_W'(1)) & msk;
		if (e == 8'hff)
			r.st = ST_NONFINITE;
		else if (ovf)
			r.st = ST_OVERFLOW;
		else
			r.st = ST_OK;
		return r;
	endfunction

	// a + RNE(w * (b - a) / 256)
	function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] w);
		logic signed [8:0]  d;
		logic signed [17:0] p;
		logic [16:0]        mg;
		logic [8:0]         q;
		d  = $signed({1'b0, b}) - $signed({1'b0, a});
		p  = $signed({1'b0, w}) * d;
		mg = p[17] ? 17'(-p) : 17'(p);
		q  = mg[16:8];
		if (mg[7:0] > 8'd128 || (mg[7:0] == 8'd128 && q[0]))
			q = q + 9'd1;
		return p[17] ? (a - q[7:0]) : (a + q[7:0]);
	endfunction

endpackage

// ----- design/tbs_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_cfg
// APB register file: texture extents and filter mode.
// ----------------------------------------------------------------------------
module tbs_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tbs_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	output tbs_pkg::cfg_t                  cfg
);
	import tbs_pkg::*;

	cfg_t cfg_q;
	logic wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			unique case (paddr[3:2])
				REG_LOG2_WIDTH:  cfg_q.log2_width  <= pwdata[LG_W-1:0];
				REG_LOG2_HEIGHT: cfg_q.log2_height <= pwdata[LG_W-1:0];
				REG_FILTER_MODE: cfg_q.filter_mode <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_LOG2_WIDTH:  prdata = 32'(cfg_q.log2_width);
			REG_LOG2_HEIGHT: prdata = 32'(cfg_q.log2_height);
			REG_FILTER_MODE: prdata = 32'(cfg_q.filter_mode);
			default:         prdata = '0;
		endcase
	end

endmodule

// ----- design/tbs_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_ctrl
// Sequencer: accept, decode, tap reads, lerps and result hand-off.
// ----------------------------------------------------------------------------
module tbs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  logic          s_tuser,
	output logic          s_tready,
	input  tbs_pkg::sts_t sts,
	output tbs_pkg::cmd_t cmd
);
	import tbs_pkg::*;

	state_t     state_q, state_d;
	logic [1:0] cnt_q;
	logic       acc;

	assign acc = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (acc && s_tuser == OP_SAMPLE) state_d = S_DECODE;
			S_DECODE: state_d = S_READ;
			S_READ: begin
				if (!sts.bilinear)
					state_d = S_DONE;
				else if (cnt_q == 2'd3)
					state_d = S_LERP_X;
			end
			S_LERP_X: state_d = S_LERP_Y;
			S_LERP_Y: state_d = S_DONE;
			S_DONE:   if (sts.out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready     = (state_q == S_IDLE);
		cmd          = '0;
		cmd.wr_en    = acc && s_tuser == OP_WRITE;
		cmd.capture  = acc;
		cmd.decode   = (state_q == S_DECODE);
		cmd.rd_en    = (state_q == S_READ);
		cmd.rd_sel   = cnt_q;
		cmd.lerp_x   = (state_q == S_LERP_X);
		cmd.lerp_y   = (state_q == S_LERP_Y);
		cmd.load_out = (state_q == S_DONE) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_q == S_READ) ? cnt_q + 2'd1 : 2'd0;
		end
	end

endmodule

// ----- design/tbs_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_dp
// Datapath: texel memory, coordinate decode, tap registers, lerp lanes and
// the output register.
// ----------------------------------------------------------------------------
module tbs_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tbs_pkg::cfg_t                 cfg,
	input  tbs_pkg::cmd_t                 cmd,
	output tbs_pkg::sts_t                 sts,
	input  logic [tbs_pkg::S_TDATA_W-1:0] s_tdata,
	output logic [31:0]                   m_tdata,
	output logic [1:0]                    m_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready
);
	import tbs_pkg::*;

	logic [31:0]       mem_q [TEXEL_WORDS];
	logic [31:0]       tap_q [4];
	logic [31:0]       cu_q, cv_q;
	logic              bil_q;
	logic [LG_W-1:0]   lgw, lgh;
	axis_t             au, av;
	logic [1:0]        st_q;
	logic [IDX_W-1:0]  xl_q, xh_q, yl_q, yh_q;
	logic [7:0]        wx_q, wy_q;
	logic [ADDR_W-1:0] rd_addr;
	logic [IDX_W-1:0]  rx, ry;
	logic [31:0]       lo_q, hi_q, res_q;
	logic              vld_q;
	logic [31:0]       out_q;
	logic [1:0]        ost_q;

	assign lgw = sat_lg(cfg.log2_width);
	assign lgh = sat_lg(cfg.log2_height);
	assign au  = axis_decode(cu_q, lgw, bil_q);
	assign av  = axis_decode(cv_q, lgh, bil_q);

	assign rx      = cmd.rd_sel[0] ? xh_q : xl_q;
	assign ry      = cmd.rd_sel[1] ? yh_q : yl_q;
	assign rd_addr = (ADDR_W'(ry) << lgw) | ADDR_W'(rx);

	assign sts.bilinear = bil_q;
	assign sts.out_free = !vld_q || m_tready;

	always_ff @(posedge clk) begin
		if (cmd.wr_en)
			mem_q[s_tdata[ADDR_W-1:0]] <= s_tdata[ADDR_W+31:ADDR_W];
		if (cmd.rd_en)
			tap_q[cmd.rd_sel] <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cu_q  <= s_tdata[75:44];
			cv_q  <= s_tdata[107:76];
			bil_q <= cfg.filter_mode;
		end
		if (cmd.decode) begin
			st_q <= (au.st != ST_OK) ? au.st : av.st;
			xl_q <= au.lo;
			xh_q <= au.hi;
			wx_q <= au.w;
			yl_q <= av.lo;
			yh_q <= av.hi;
			wy_q <= av.w;
		end
		if (cmd.lerp_x) begin
			for (int ch = 0; ch < 4; ch++) begin
				lo_q[ch*8 +: 8] <= lerp8(tap_q[0][ch*8 +: 8], tap_q[1][ch*8 +: 8], wx_q);
				hi_q[ch*8 +: 8] <= lerp8(tap_q[2][ch*8 +: 8], tap_q[3][ch*8 +: 8], wx_q);
			end
		end
		if (cmd.lerp_y) begin
			for (int ch = 0; ch < 4; ch++)
				res_q[ch*8 +: 8] <= lerp8(lo_q[ch*8 +: 8], hi_q[ch*8 +: 8], wy_q);
		end
		if (cmd.load_out) begin
			ost_q <= st_q;
			if (st_q != ST_OK)
				out_q <= '0;
			else
				out_q <= bil_q ? res_q : tap_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= 1'b0;
		else if (cmd.load_out)
			vld_q <= 1'b1;
		else if (m_tready)
			vld_q <= 1'b0;
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = out_q;
	assign m_tuser  = ost_q;

endmodule

// ----- design/texture_bilinear_sampler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_bilinear_sampler
// Bilinear or nearest RGBA8 sampler over a 4096-word texel memory.
// ----------------------------------------------------------------------------
// A write transfer (tuser 0) stores one texel in the cycle it is accepted and
// returns nothing. A sample transfer (tuser 1) returns one result: accept,
// decode, then one single-port memory read per tap (1 in nearest mode, 4 in
// bilinear), a lerp along x and then one along y in bilinear mode, and a load
// of the output register, which waits until that register is free. The tap
// reads share the single memory port. A finished result waits in the output
// register while the next transfer is accepted.
module texture_bilinear_sampler
	import tbs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// texel_index[11:0], texel_data[43:12], coord_u[75:44], coord_v[107:76], zero
	input  logic [S_TDATA_W-1:0]  s_tdata,
	// operation[0]
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// rgba[31:0]
	output logic [31:0]           m_tdata,
	// status[1:0]
	output logic [1:0]            m_tuser
);
	`include "assert_macros.svh"

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	tbs_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	tbs_ctrl u_ctrl (
		.clk, .arst_n, .s_tvalid, .s_tuser, .s_tready, .sts, .cmd
	);

	tbs_dp u_dp (
		.clk, .arst_n, .cfg, .cmd, .sts, .s_tdata, .m_tdata, .m_tuser, .m_tvalid, .m_tready
	);

	`ASSERT_CLK(a_status_code, clk, arst_n, !m_tvalid || m_tuser != 2'd3, "bad status code")
	`ASSERT_IMPL(a_err_zero, clk, arst_n, m_tvalid && m_tuser != ST_OK, m_tdata == 32'd0,
		"error result carries data")
	`ASSERT_IMPL(a_busy_no_accept, clk, arst_n, cmd.rd_en || cmd.lerp_x || cmd.lerp_y,
		!s_tready, "input accepted while sample in flight")

endmodule
